>>> src/gauss_jordan_full_pivot_solve_macros.svh
// assertion macros for the solver rtl, included by the sequencer
// expects signals named clock and reset in the including scope
`ifndef GAUSS_JORDAN_FULL_PIVOT_SOLVE_MACROS_SVH
`define GAUSS_JORDAN_FULL_PIVOT_SOLVE_MACROS_SVH

// same-cycle implication, masked during reset
`define GJFP_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("implication check failed");

// next-cycle implication, masked during reset
`define GJFP_ASSERT_NEXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

>>> src/gjfp_pkg.sv
// shared types, codes and saturation helper for the gauss-jordan solver
// no dependencies
`timescale 1ns / 1ps

package gjfp_pkg;

   localparam int WORD_W     = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_RUN     = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   localparam logic CSR_SIZE = 1'b0;
   localparam logic CSR_RHS  = 1'b1;

   typedef enum logic [2:0] {
      WSRC_LOAD,
      WSRC_RDATA,
      WSRC_HOLD,
      WSRC_ONE,
      WSRC_ZERO,
      WSRC_CLAMP,
      WSRC_DIFF
   } wsrc_type;

   typedef struct packed {
      logic     re;
      logic     we;
      wsrc_type wsrc;
      logic     hold_load;
      logic     f_load;
      logic     prod_load;
      logic     mul_f;
      logic     clamp_load;
      logic     big_clear;
      logic     cmp_en;
      logic     div_start;
      logic     sat_clear;
   } cmd_type;

   typedef struct packed {
      logic better;
      logic rd_zero;
      logic div_done;
      logic sat;
   } stat_type;

   typedef struct packed {
      logic              sat;
      logic [WORD_W-1:0] value;
   } clamp_type;

   function automatic clamp_type clamp_word(input logic signed [65:0] v);
      clamp_type r;
      if (v > 66'sd2147483647) begin
         r.sat   = 1'b1;
         r.value = 32'h7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         r.sat   = 1'b1;
         r.value = 32'h8000_0000;
      end else begin
         r.sat   = 1'b0;
         r.value = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/gjfp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module gjfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/gjfp_datapath.sv
// element store, multiplier, saturation, pivot compare and reciprocal divider
// depends on gjfp_pkg and gjfp_ram
`timescale 1ns / 1ps

module gjfp_datapath #(
   parameter int FRAC_BITS = 16,
   parameter int AW        = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gjfp_pkg::cmd_type           cmd,
   input  logic [AW-1:0]               waddr,
   input  logic [AW-1:0]               raddr,
   input  logic [gjfp_pkg::WORD_W-1:0] load_data,
   output logic [gjfp_pkg::WORD_W-1:0] rd_data,
   output gjfp_pkg::stat_type          stat
);

   localparam int NBITS = 2 * FRAC_BITS + 1;
   localparam int CNTW  = $clog2(NBITS + 1);

   logic [31:0]        wdata;
   logic signed [31:0] f_ff, inv_ff;
   logic [31:0]        hold_ff, clamp_ff;
   logic signed [63:0] prod_ff;
   logic [32:0]        big_ff;
   logic               sat_ff;
   logic               busy_ff, neg_ff;
   logic [CNTW-1:0]    cnt_ff;
   logic [31:0]        d_ff, rem_ff;
   logic [NBITS-1:0]   q_ff;

   logic [32:0]           mag;
   logic signed [63:0]    shifted;
   logic signed [32:0]    diff;
   gjfp_pkg::clamp_type   mul_cl, diff_cl, div_cl;
   logic [32:0]           rem_sh, rem_in;
   logic                  ge, div_fin;
   logic signed [65:0]    qx, qs;

   gjfp_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_store (
      .clock (clock),
      .we    (cmd.we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.re),
      .raddr (raddr),
      .rdata (rd_data)
   );

   assign mag     = rd_data[31] ? (33'd0 - {1'b1, rd_data}) : {1'b0, rd_data};
   assign shifted = prod_ff >>> FRAC_BITS;
   assign mul_cl  = gjfp_pkg::clamp_word(66'(shifted));
   assign diff    = $signed({rd_data[31], rd_data}) - $signed({clamp_ff[31], clamp_ff});
   assign diff_cl = gjfp_pkg::clamp_word(66'(diff));

   // restoring divide of one shifted left by twice the fraction width
   assign rem_sh  = {rem_ff, (cnt_ff == '0)};
   assign ge      = rem_sh >= {1'b0, d_ff};
   assign rem_in  = ge ? (rem_sh - {1'b0, d_ff}) : rem_sh;
   assign div_fin = busy_ff && (cnt_ff == CNTW'(NBITS));
   assign qx      = $signed(66'(q_ff));
   assign qs      = neg_ff ? (66'sd0 - qx - $signed({65'd0, (rem_ff != 32'd0)})) : qx;
   assign div_cl  = gjfp_pkg::clamp_word(qs);

   always_comb begin
      case (cmd.wsrc)
         gjfp_pkg::WSRC_LOAD:  wdata = load_data;
         gjfp_pkg::WSRC_RDATA: wdata = rd_data;
         gjfp_pkg::WSRC_HOLD:  wdata = hold_ff;
         gjfp_pkg::WSRC_ONE:   wdata = 32'd1 << FRAC_BITS;
         gjfp_pkg::WSRC_CLAMP: wdata = clamp_ff;
         gjfp_pkg::WSRC_DIFF:  wdata = diff_cl.value;
         default:              wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_load) begin
         hold_ff <= rd_data;
      end
      if (cmd.f_load) begin
         f_ff <= $signed(rd_data);
      end
      if (cmd.prod_load) begin
         prod_ff <= $signed(rd_data) * (cmd.mul_f ? f_ff : inv_ff);
      end
      if (cmd.clamp_load) begin
         clamp_ff <= mul_cl.value;
      end
      if (cmd.big_clear) begin
         big_ff <= '0;
      end else if (cmd.cmp_en && (mag >= big_ff)) begin
         big_ff <= mag;
      end
      if (cmd.div_start) begin
         neg_ff <= rd_data[31];
         d_ff   <= rd_data[31] ? (~rd_data + 32'd1) : rd_data;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff && !div_fin) begin
         rem_ff <= rem_in[31:0];
         q_ff   <= {q_ff[NBITS-2:0], ge};
      end
      if (div_fin) begin
         inv_ff <= $signed(div_cl.value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         sat_ff  <= 1'b0;
      end else begin
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (div_fin) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.sat_clear) begin
            sat_ff <= 1'b0;
         end else if ((cmd.clamp_load && mul_cl.sat) || (div_fin && div_cl.sat) ||
                      (cmd.we && (cmd.wsrc == gjfp_pkg::WSRC_DIFF) && diff_cl.sat)) begin
            sat_ff <= 1'b1;
         end
      end
   end

   assign stat.better   = mag >= big_ff;
   assign stat.rd_zero  = (rd_data == 32'd0);
   assign stat.div_done = div_fin;
   assign stat.sat      = sat_ff;

endmodule

>>> src/gjfp_ctrl.sv
// sequencer: loads, pivot search, swaps, scaling, elimination, unswap, result beats
// depends on gjfp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "gauss_jordan_full_pivot_solve_macros.svh"

module gjfp_ctrl #(
   parameter int MAX_ORDER = 4,
   parameter int MAX_RHS   = 4,
   parameter int AW        = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gjfp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gjfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [2:0]                      csr_data,
   output gjfp_pkg::cmd_type               cmd,
   output logic [AW-1:0]                   waddr,
   output logic [AW-1:0]                   raddr,
   output logic [gjfp_pkg::WORD_W-1:0]     load_data,
   input  logic [gjfp_pkg::WORD_W-1:0]     rd_data,
   input  gjfp_pkg::stat_type              stat
);

   localparam int COLS = MAX_ORDER + MAX_RHS;
   localparam int IW   = $clog2(MAX_ORDER);
   localparam int CW   = $clog2(COLS);
   localparam int NW   = $clog2(MAX_ORDER + 1);
   localparam int MW   = $clog2(MAX_RHS + 1);
   localparam int XW   = NW + CW + MW + 2;

   typedef enum logic [4:0] {
      S_IDLE, S_SRCH_INIT, S_SRCH_RD, S_SRCH_CMP, S_MARK,
      S_SW_RD0, S_SW_RD1, S_SW_WR0, S_SW_WR1,
      S_PIV_RD, S_PIV_CHK, S_DIV,
      S_SC_RD, S_SC_MUL, S_SC_CLP, S_SC_WR,
      S_EL_FRD, S_EL_F, S_EL_RD, S_EL_MUL, S_EL_CLP, S_EL_WR,
      S_UN_CHK, S_UN_NEXT,
      S_OUT_RD, S_OUT_LD, S_OUT_HOLD, S_SING_HOLD
   } state_type;

   state_type           state_ff;
   logic [2:0]          size_ff, rhs_ff;
   logic [NW-1:0]       n_ff, iter_ff, rowc_ff, kc_ff;
   logic [MW-1:0]       m_ff;
   logic [CW-1:0]       colc_ff;
   logic [IW-1:0]       prow_ff, pcol_ff;
   logic [MAX_ORDER-1:0] used_ff;
   logic [IW-1:0]       row_log_ff [MAX_ORDER];
   logic [IW-1:0]       col_log_ff [MAX_ORDER];
   logic                unsw_ff, phase_ff;
   logic                rsp_valid_ff, rsp_which_ff, rsp_last_ff;
   logic [1:0]          rsp_row_ff, rsp_col_ff, rsp_status_ff;
   logic [31:0]         rsp_value_ff;

   logic [1:0]    op, ld_row, ld_col;
   logic          req_fire, ld_ok_a, ld_ok_b;
   logic [AW-1:0] ld_addr, sw_a0, sw_a1;
   logic [IW-1:0] lr, lc;
   logic [NW-1:0] n_eff;
   logic [MW-1:0] m_eff;
   logic          col_ok, col_last, rowc_last, kc_last, iter_last, eligible;
   logic          srch_adv, el_adv, out_colend, out_last;

   function automatic logic [AW-1:0] adr(input logic [IW-1:0] r, input logic [CW-1:0] c);
      return {r, c};
   endfunction

   assign op       = req_tuser;
   assign ld_row   = req_tdata[1:0];
   assign ld_col   = req_tdata[3:2];
   assign req_fire = req_tvalid && req_tready;
   assign ld_ok_a  = (op == gjfp_pkg::OP_WRITE_A) && (XW'(ld_row) < XW'(MAX_ORDER)) &&
                     (XW'(ld_col) < XW'(MAX_ORDER));
   assign ld_ok_b  = (op == gjfp_pkg::OP_WRITE_B) && (XW'(ld_row) < XW'(MAX_ORDER)) &&
                     (XW'(ld_col) < XW'(MAX_RHS));
   assign ld_addr  = adr(IW'(ld_row), ld_ok_b ? (CW'(MAX_ORDER) + CW'(ld_col)) : CW'(ld_col));
   assign load_data = req_tdata[35:4];

   assign n_eff = (size_ff == 3'd0) ? NW'(1) :
                  (XW'(size_ff) > XW'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(size_ff);
   assign m_eff = (XW'(rhs_ff) > XW'(MAX_RHS)) ? MW'(MAX_RHS) : MW'(rhs_ff);

   assign lr = row_log_ff[iter_ff[IW-1:0]];
   assign lc = col_log_ff[iter_ff[IW-1:0]];

   // columns of A up to n, then the m live columns of B
   assign col_ok    = (XW'(colc_ff) < XW'(n_ff)) ||
                      ((XW'(colc_ff) >= XW'(MAX_ORDER)) &&
                       (XW'(colc_ff) < XW'(MAX_ORDER) + XW'(m_ff)));
   assign col_last  = (colc_ff == CW'(COLS - 1));
   assign rowc_last = (rowc_ff == n_ff - NW'(1));
   assign kc_last   = (kc_ff == n_ff - NW'(1));
   assign iter_last = (iter_ff == n_ff - NW'(1));
   assign eligible  = !used_ff[rowc_ff[IW-1:0]] && !used_ff[kc_ff[IW-1:0]];

   assign sw_a0 = unsw_ff ? adr(rowc_ff[IW-1:0], CW'(lr)) : adr(prow_ff, colc_ff);
   assign sw_a1 = unsw_ff ? adr(rowc_ff[IW-1:0], CW'(lc)) : adr(pcol_ff, colc_ff);

   assign srch_adv = ((state_ff == S_SRCH_RD) && !eligible) || (state_ff == S_SRCH_CMP);
   assign el_adv   = ((state_ff == S_EL_FRD) && (rowc_ff[IW-1:0] == pcol_ff)) ||
                     ((state_ff == S_EL_RD) && !col_ok && col_last) ||
                     ((state_ff == S_EL_WR) && col_last);

   assign out_colend = phase_ff ? (XW'(colc_ff) + XW'(1) == XW'(MAX_ORDER) + XW'(m_ff)) :
                                  (XW'(colc_ff) + XW'(1) == XW'(n_ff));
   assign out_last   = out_colend && rowc_last && (phase_ff || (m_ff == '0));

   always_comb begin
      cmd   = '0;
      waddr = '0;
      raddr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (ld_ok_a || ld_ok_b)) begin
               cmd.we   = 1'b1;
               cmd.wsrc = gjfp_pkg::WSRC_LOAD;
               waddr    = ld_addr;
            end
            cmd.sat_clear = req_fire && (op == gjfp_pkg::OP_RUN);
         end
         S_SRCH_INIT: cmd.big_clear = 1'b1;
         S_SRCH_RD: begin
            cmd.re = eligible;
            raddr  = adr(rowc_ff[IW-1:0], CW'(kc_ff));
         end
         S_SRCH_CMP: cmd.cmp_en = 1'b1;
         S_SW_RD0: begin
            cmd.re = unsw_ff || col_ok;
            raddr  = sw_a0;
         end
         S_SW_RD1: begin
            cmd.re        = 1'b1;
            cmd.hold_load = 1'b1;
            raddr         = sw_a1;
         end
         S_SW_WR0: begin
            cmd.we   = 1'b1;
            cmd.wsrc = gjfp_pkg::WSRC_RDATA;
            waddr    = sw_a0;
         end
         S_SW_WR1: begin
            cmd.we   = 1'b1;
            cmd.wsrc = gjfp_pkg::WSRC_HOLD;
            waddr    = sw_a1;
         end
         S_PIV_RD: begin
            cmd.re = 1'b1;
            raddr  = adr(pcol_ff, CW'(pcol_ff));
         end
         S_PIV_CHK: begin
            if (!stat.rd_zero) begin
               cmd.div_start = 1'b1;
               cmd.we        = 1'b1;
               cmd.wsrc      = gjfp_pkg::WSRC_ONE;
               waddr         = adr(pcol_ff, CW'(pcol_ff));
            end
         end
         S_SC_RD: begin
            cmd.re = col_ok;
            raddr  = adr(pcol_ff, colc_ff);
         end
         S_SC_MUL: cmd.prod_load = 1'b1;
         S_SC_CLP, S_EL_CLP: cmd.clamp_load = 1'b1;
         S_SC_WR: begin
            cmd.we   = 1'b1;
            cmd.wsrc = gjfp_pkg::WSRC_CLAMP;
            waddr    = adr(pcol_ff, colc_ff);
         end
         S_EL_FRD: begin
            cmd.re = (rowc_ff[IW-1:0] != pcol_ff);
            raddr  = adr(rowc_ff[IW-1:0], CW'(pcol_ff));
         end
         S_EL_F: begin
            cmd.f_load = 1'b1;
            cmd.we     = 1'b1;
            cmd.wsrc   = gjfp_pkg::WSRC_ZERO;
            waddr      = adr(rowc_ff[IW-1:0], CW'(pcol_ff));
         end
         S_EL_RD: begin
            cmd.re = col_ok;
            raddr  = adr(pcol_ff, colc_ff);
         end
         S_EL_MUL: begin
            cmd.prod_load = 1'b1;
            cmd.mul_f     = 1'b1;
            cmd.re        = 1'b1;
            raddr         = adr(rowc_ff[IW-1:0], colc_ff);
         end
         S_EL_WR: begin
            cmd.we   = 1'b1;
            cmd.wsrc = gjfp_pkg::WSRC_DIFF;
            waddr    = adr(rowc_ff[IW-1:0], colc_ff);
         end
         S_OUT_RD: begin
            cmd.re = 1'b1;
            raddr  = adr(rowc_ff[IW-1:0], colc_ff);
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         size_ff      <= 3'd4;
         rhs_ff       <= 3'd1;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               gjfp_pkg::CSR_SIZE: size_ff <= csr_data;
               gjfp_pkg::CSR_RHS:  rhs_ff  <= csr_data;
               default:            size_ff <= size_ff;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (op == gjfp_pkg::OP_RUN)) begin
                  n_ff     <= n_eff;
                  m_ff     <= m_eff;
                  used_ff  <= '0;
                  iter_ff  <= '0;
                  state_ff <= S_SRCH_INIT;
               end
            end
            S_SRCH_INIT: begin
               rowc_ff  <= '0;
               kc_ff    <= '0;
               prow_ff  <= '0;
               pcol_ff  <= '0;
               state_ff <= S_SRCH_RD;
            end
            S_SRCH_RD: begin
               if (eligible) state_ff <= S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
               // later elements win ties
               if (stat.better) begin
                  prow_ff <= rowc_ff[IW-1:0];
                  pcol_ff <= kc_ff[IW-1:0];
               end
            end
            S_MARK: begin
               used_ff[pcol_ff]            <= 1'b1;
               row_log_ff[iter_ff[IW-1:0]] <= prow_ff;
               col_log_ff[iter_ff[IW-1:0]] <= pcol_ff;
               colc_ff                     <= '0;
               unsw_ff                     <= 1'b0;
               state_ff <= (prow_ff != pcol_ff) ? S_SW_RD0 : S_PIV_RD;
            end
            S_SW_RD0: begin
               if (!unsw_ff && !col_ok) begin
                  if (col_last) state_ff <= S_PIV_RD;
                  else colc_ff <= colc_ff + 1'b1;
               end else begin
                  state_ff <= S_SW_RD1;
               end
            end
            S_SW_RD1: state_ff <= S_SW_WR0;
            S_SW_WR0: state_ff <= S_SW_WR1;
            S_SW_WR1: begin
               if (unsw_ff) begin
                  if (rowc_last) begin
                     state_ff <= S_UN_NEXT;
                  end else begin
                     rowc_ff  <= rowc_ff + 1'b1;
                     state_ff <= S_SW_RD0;
                  end
               end else if (col_last) begin
                  state_ff <= S_PIV_RD;
               end else begin
                  colc_ff  <= colc_ff + 1'b1;
                  state_ff <= S_SW_RD0;
               end
            end
            S_PIV_RD: state_ff <= S_PIV_CHK;
            S_PIV_CHK: begin
               if (stat.rd_zero) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_which_ff  <= 1'b0;
                  rsp_row_ff    <= '0;
                  rsp_col_ff    <= '0;
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= gjfp_pkg::ST_SINGULAR;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_SING_HOLD;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (stat.div_done) begin
                  colc_ff  <= '0;
                  state_ff <= S_SC_RD;
               end
            end
            S_SC_RD: begin
               if (!col_ok) begin
                  if (col_last) begin
                     rowc_ff  <= '0;
                     state_ff <= S_EL_FRD;
                  end else begin
                     colc_ff <= colc_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_SC_MUL;
               end
            end
            S_SC_MUL: state_ff <= S_SC_CLP;
            S_SC_CLP: state_ff <= S_SC_WR;
            S_SC_WR: begin
               if (col_last) begin
                  rowc_ff  <= '0;
                  state_ff <= S_EL_FRD;
               end else begin
                  colc_ff  <= colc_ff + 1'b1;
                  state_ff <= S_SC_RD;
               end
            end
            S_EL_FRD: begin
               if (rowc_ff[IW-1:0] != pcol_ff) state_ff <= S_EL_F;
            end
            S_EL_F: begin
               colc_ff  <= '0;
               state_ff <= S_EL_RD;
            end
            S_EL_RD: begin
               if (!col_ok) colc_ff <= colc_ff + 1'b1;
               else state_ff <= S_EL_MUL;
            end
            S_EL_MUL: state_ff <= S_EL_CLP;
            S_EL_CLP: state_ff <= S_EL_WR;
            S_EL_WR: begin
               colc_ff <= colc_ff + 1'b1;
               if (!col_last) state_ff <= S_EL_RD;
            end
            S_UN_CHK: begin
               if (lr != lc) begin
                  unsw_ff  <= 1'b1;
                  rowc_ff  <= '0;
                  state_ff <= S_SW_RD0;
               end else begin
                  state_ff <= S_UN_NEXT;
               end
            end
            S_UN_NEXT: begin
               if (iter_ff == '0) begin
                  rowc_ff  <= '0;
                  colc_ff  <= '0;
                  phase_ff <= 1'b0;
                  state_ff <= S_OUT_RD;
               end else begin
                  iter_ff  <= iter_ff - 1'b1;
                  state_ff <= S_UN_CHK;
               end
            end
            S_OUT_RD: state_ff <= S_OUT_LD;
            S_OUT_LD: begin
               rsp_valid_ff  <= 1'b1;
               rsp_which_ff  <= phase_ff;
               rsp_row_ff    <= 2'(rowc_ff);
               rsp_col_ff    <= phase_ff ? 2'(colc_ff - CW'(MAX_ORDER)) : 2'(colc_ff);
               rsp_value_ff  <= rd_data;
               rsp_status_ff <= stat.sat ? gjfp_pkg::ST_SAT : gjfp_pkg::ST_OK;
               rsp_last_ff   <= out_last;
               state_ff      <= S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (out_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_OUT_RD;
                     if (out_colend) begin
                        if (rowc_last) begin
                           phase_ff <= 1'b1;
                           rowc_ff  <= '0;
                           colc_ff  <= CW'(MAX_ORDER);
                        end else begin
                           rowc_ff <= rowc_ff + 1'b1;
                           colc_ff <= phase_ff ? CW'(MAX_ORDER) : '0;
                        end
                     end else begin
                        colc_ff <= colc_ff + 1'b1;
                     end
                  end
               end
            end
            S_SING_HOLD: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // row-major walk over the live square for the pivot search
         if (srch_adv) begin
            if (kc_last) begin
               kc_ff <= '0;
               if (rowc_last) begin
                  state_ff <= S_MARK;
               end else begin
                  rowc_ff  <= rowc_ff + 1'b1;
                  state_ff <= S_SRCH_RD;
               end
            end else begin
               kc_ff    <= kc_ff + 1'b1;
               state_ff <= S_SRCH_RD;
            end
         end

         // next row to clear, or next pivot step, or on to the column unswap
         if (el_adv) begin
            if (rowc_last) begin
               if (iter_last) begin
                  state_ff <= S_UN_CHK;
               end else begin
                  iter_ff  <= iter_ff + 1'b1;
                  state_ff <= S_SRCH_INIT;
               end
            end else begin
               rowc_ff  <= rowc_ff + 1'b1;
               state_ff <= S_EL_FRD;
            end
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_which_ff};
   assign rsp_tlast  = rsp_last_ff;

   `GJFP_ASSERT_IMP(a_rsp_blocks_req, rsp_valid_ff, !req_tready)
   `GJFP_ASSERT_IMP(a_div_done_in_div, stat.div_done, state_ff == S_DIV)
   `GJFP_ASSERT_NEXT(a_mark_sets_used, state_ff == S_MARK, used_ff[pcol_ff] == 1'b1)

endmodule

>>> src/gauss_jordan_full_pivot_solve.sv
// gauss-jordan solver with full pivoting on q16.16 elements
// load beats (write A or B element) are taken one beat a cycle while the sequencer is idle
// a run beat walks the live square for each pivot search, runs the reciprocal
// divider, scales and eliminates element by element, unswaps, then sends the
// result beats; the one-read one-write element store paces all of it
// synchronous active-high reset clears the sequencer, the pivot marks and the
// size and rhs registers (4 and 1); the element store is not cleared
`timescale 1ns / 1ps

module gauss_jordan_full_pivot_solve #(
   parameter int MAX_ORDER = 4,
   parameter int MAX_RHS   = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beats
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gjfp_pkg::REQ_DATA_W-1:0] req_tdata,  // row[1:0], col[3:2], value[35:4]
   input  logic [1:0]                      req_tuser,  // opcode[1:0]
   // result beats
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gjfp_pkg::RSP_DATA_W-1:0] rsp_tdata,  // row_res[1:0], col_res[3:2], value_res[35:4]
   output logic [2:0]                      rsp_tuser,  // which_matrix[0], status[2:1]
   output logic                            rsp_tlast,  // last
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,  // 0 size_in_use, 1 rhs_count
   input  logic [2:0]                      csr_data
);

   // store row address above a column address that spans A then B
   localparam int AW = $clog2(MAX_ORDER) + $clog2(MAX_ORDER + MAX_RHS);

   gjfp_pkg::cmd_type           cmd;
   gjfp_pkg::stat_type          stat;
   logic [AW-1:0]               waddr, raddr;
   logic [gjfp_pkg::WORD_W-1:0] load_data, rd_data;

   // sequencer: owns the handshakes, counters, pivot marks and logs
   gjfp_ctrl #(
      .MAX_ORDER (MAX_ORDER),
      .MAX_RHS   (MAX_RHS),
      .AW        (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .waddr      (waddr),
      .raddr      (raddr),
      .load_data  (load_data),
      .rd_data    (rd_data),
      .stat       (stat)
   );

   // datapath: element store, floored multiply, saturation, reciprocal
   gjfp_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .AW        (AW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .waddr     (waddr),
      .raddr     (raddr),
      .load_data (load_data),
      .rd_data   (rd_data),
      .stat      (stat)
   );

endmodule
